// ===== hdl/gxy2_pkg.sv =====
// gxy2_pkg: shared constants, types and port pattern tables for the xy2 frame encoder
// no dependencies; imported by the interfaces, the frame builder and the top level
`timescale 1ns / 1ps
`default_nettype none

package gxy2_pkg;

    localparam int FrameBits = 20;
    localparam int PosWidth  = 16;
    localparam int ModeWidth = 8;
    localparam int ByteWidth = 8;
    localparam int CntWidth  = $clog2(FrameBits);

    localparam logic [2:0]  PosHead  = 3'b001;
    localparam logic [10:0] ModeHead = 11'h705;

    localparam logic [CntWidth-1:0] LastIdx = CntWidth'(FrameBits - 1);

    typedef logic [FrameBits-1:0] frame_t;
    typedef logic [15:0]          pattern_t;

    typedef struct packed {
        frame_t ch1;
        frame_t ch2;
    } frame_pair_t;

    // channel bit pair -> port pattern (sync high for data bits, sync low on the last)
    function automatic pattern_t port_pattern(input logic [1:0] sel, input logic sync_low);
        pattern_t pat;
        pat = 16'hD2C3;
        case ({sync_low, sel})
            3'b000:  pat = 16'hD2C3;
            3'b001:  pat = 16'h9687;
            3'b010:  pat = 16'h5A4B;
            3'b011:  pat = 16'h1E0F;
            3'b100:  pat = 16'hF0E1;
            3'b101:  pat = 16'hB4A5;
            3'b110:  pat = 16'h7869;
            3'b111:  pat = 16'h3C2D;
            default: pat = 16'hD2C3;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gxy2_cmd_if.sv =====
// gxy2_cmd_if: valid/ready command channel carrying one position or mode command
// depends on gxy2_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gxy2_cmd_if
    import gxy2_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [PosWidth-1:0]  x_position;
    logic [PosWidth-1:0]  y_position;
    logic [ModeWidth-1:0] output_mode;

    modport source (
        output valid, action, x_position, y_position, output_mode,
        input  ready
    );
    modport sink (
        input  valid, action, x_position, y_position, output_mode,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/gxy2_port_if.sv =====
// gxy2_port_if: valid/ready channel carrying one frame bit as two port bytes
// depends on gxy2_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gxy2_port_if
    import gxy2_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] first_port_byte;
    logic [ByteWidth-1:0] second_port_byte;
    logic                 last_bit;

    modport source (
        output valid, first_port_byte, second_port_byte, last_bit,
        input  ready
    );
    modport sink (
        input  valid, first_port_byte, second_port_byte, last_bit,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/galvo_xy2_frame_encoder.sv =====
// galvo_xy2_frame_encoder: top level, serializes xy2 style galvo frames into port patterns
// depends on gxy2_pkg, gxy2_cmd_if, gxy2_port_if, gxy2_frame_build
//
// usage
//   cmd   : sink channel, one item per command (position pair or output mode)
//   port  : source channel, twenty items per command, frame bit 19 first;
//           first_port_byte is driven in the clock low phase, second_port_byte
//           in the clock high phase; last_bit marks frame bit 0 (sync low)
//   first bit: an accepted command is loaded into the bit shifter, and its
//           first bit then passes through the output register to the port
//   throughput: one bit item per cycle while port.ready is high, set by the
//           bit shifter that walks the frame; the next command is taken in the
//           same cycle that the last bit moves into the output register, so
//           frames run back to back with no gap
//   stall: while port.ready is low the output register holds, the shifter
//           waits, and cmd.ready drops once a frame is loaded
//   reset: rst_n low clears the shifter busy flag, the bit counter and output
//           valid; no frame in flight survives reset
`timescale 1ns / 1ps
`default_nettype none

module galvo_xy2_frame_encoder
    import gxy2_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    gxy2_cmd_if.sink     cmd,
    gxy2_port_if.source  port
);

    // frames built straight from the command fields
    frame_pair_t frames;

    gxy2_frame_build u_frame_build (
        .action      (cmd.action),
        .x_position  (cmd.x_position),
        .y_position  (cmd.y_position),
        .output_mode (cmd.output_mode)
        ,.frames     (frames)
    );

    // bit shifter: both channel frames, msb goes out next
    frame_t              ch1_reg, ch1_next;
    frame_t              ch2_reg, ch2_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [ByteWidth-1:0] first_reg, first_next;
    logic [ByteWidth-1:0] second_reg, second_next;
    logic                 last_reg, last_next;

    logic     advance;
    logic     final_bit;
    logic     cmd_take;
    pattern_t pat;

    // shifter moves one bit into the output register when that register is free
    assign advance   = busy_reg && (!out_valid_reg || port.ready);
    assign final_bit = (cnt_reg == LastIdx);
    assign cmd.ready = !busy_reg || (advance && final_bit);
    assign cmd_take  = cmd.valid && cmd.ready;

    assign pat = port_pattern({ch2_reg[FrameBits-1], ch1_reg[FrameBits-1]}, final_bit);

    always_comb
    begin
        ch1_next  = ch1_reg;
        ch2_next  = ch2_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (advance)
        begin
            ch1_next = {ch1_reg[FrameBits-2:0], 1'b0};
            ch2_next = {ch2_reg[FrameBits-2:0], 1'b0};
            cnt_next = cnt_reg + CntWidth'(1);
            if (final_bit)
            begin
                busy_next = 1'b0;
            end
        end
        // a new command loads over the shifted-out frame
        if (cmd_take)
        begin
            ch1_next  = frames.ch1;
            ch2_next  = frames.ch2;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            first_next     = pat[ByteWidth-1:0];
            second_next    = pat[2*ByteWidth-1:ByteWidth];
            last_next      = final_bit;
        end
        else if (port.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        ch1_reg    <= ch1_next;
        ch2_reg    <= ch2_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        last_reg   <= last_next;
    end

    assign port.valid            = out_valid_reg;
    assign port.first_port_byte  = first_reg;
    assign port.second_port_byte = second_reg;
    assign port.last_bit         = last_reg;

    // a command is only taken when the shifter is empty or on its last bit
    a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> (!busy_reg || (advance && final_bit)))
        else $error("command accepted while a frame is still shifting");

    // bit counter never runs past the frame
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= LastIdx))
        else $error("bit counter out of range");

    // the final shifted bit shows up flagged as last
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && final_bit) |=> (port.valid && port.last_bit))
        else $error("final frame bit not marked last");

endmodule

`default_nettype wire

// ===== hdl/gxy2_frame_build.sv =====
// gxy2_frame_build: forms the two 20-bit channel frames with even parity
// depends on gxy2_pkg
`timescale 1ns / 1ps
`default_nettype none

module gxy2_frame_build
    import gxy2_pkg::*;
(
    input  wire logic                 action,
    input  wire logic [PosWidth-1:0]  x_position,
    input  wire logic [PosWidth-1:0]  y_position,
    input  wire logic [ModeWidth-1:0] output_mode,
    output frame_pair_t               frames
);

    logic [FrameBits-2:0] ch1_body;
    logic [FrameBits-2:0] ch2_body;

    always_comb
    begin
        if (action)
        begin
            ch1_body = {ModeHead, output_mode};
            ch2_body = {ModeHead, output_mode};
        end
        else
        begin
            ch1_body = {PosHead, x_position};
            ch2_body = {PosHead, y_position};
        end
        // parity bit makes the count of ones even
        frames.ch1 = {ch1_body, ^ch1_body};
        frames.ch2 = {ch2_body, ^ch2_body};
    end

endmodule

`default_nettype wire

// ===== sim/tb_galvo_xy2_frame_encoder.sv =====
// tb_galvo_xy2_frame_encoder: self-checking bench for the xy2 frame encoder
// depends on gxy2_pkg, gxy2_cmd_if, gxy2_port_if and galvo_xy2_frame_encoder
`timescale 1ns / 1ps

module tb_galvo_xy2_frame_encoder;

    import gxy2_pkg::*;

    // command codes carried on cmd.action
    localparam logic ActPosition = 1'b0;
    localparam logic ActMode     = 1'b1;

    // port patterns indexed by {ch2 bit, ch1 bit}
    localparam pattern_t SyncHighPat [4] = '{16'hD2C3, 16'h9687, 16'h5A4B, 16'h1E0F};
    localparam pattern_t SyncLowPat  [4] = '{16'hF0E1, 16'hB4A5, 16'h7869, 16'h3C2D};

    typedef struct {
        logic                 action;
        logic [PosWidth-1:0]  x_position;
        logic [PosWidth-1:0]  y_position;
        logic [ModeWidth-1:0] output_mode;
    } command_t;

    typedef struct {
        logic [ByteWidth-1:0] first_port_byte;
        logic [ByteWidth-1:0] second_port_byte;
        logic                 last_bit;
    } port_bits_t;

    // builds both channel frames per command and holds the twenty port items it implies
    class xy2_bit_checker;
        port_bits_t  expected_bits[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // even parity lands in bit 0, which is zero on entry
        function frame_t with_parity(input frame_t f);
            frame_t r;
            r    = f;
            r[0] = ^f;
            return r;
        endfunction

        function void note_command(input command_t c);
            frame_t     ch1;
            frame_t     ch2;
            logic [1:0] sel;
            pattern_t   pat;
            port_bits_t e;
            if (c.action == ActMode)
            begin
                ch1 = with_parity({ModeHead, c.output_mode, 1'b0});
                ch2 = ch1;
            end
            else
            begin
                ch1 = with_parity({PosHead, c.x_position, 1'b0});
                ch2 = with_parity({PosHead, c.y_position, 1'b0});
            end
            for (int b = FrameBits - 1; b >= 0; b--)
            begin
                sel                = {ch2[b], ch1[b]};
                pat                = (b == 0) ? SyncLowPat[sel] : SyncHighPat[sel];
                e.first_port_byte  = pat[7:0];
                e.second_port_byte = pat[15:8];
                e.last_bit         = (b == 0);
                expected_bits.push_back(e);
            end
        endfunction

        function void check_port_item(input logic [ByteWidth-1:0] first_b,
                                      input logic [ByteWidth-1:0] second_b,
                                      input logic                 last_b);
            port_bits_t e;
            if (expected_bits.size() == 0)
            begin
                $error("port item with no command pending: first %0h second %0h last %0b",
                       first_b, second_b, last_b);
                errors++;
                return;
            end
            e = expected_bits.pop_front();
            if (first_b !== e.first_port_byte)
            begin
                $error("first_port_byte: expected %0h, actual %0h", e.first_port_byte, first_b);
                errors++;
            end
            if (second_b !== e.second_port_byte)
            begin
                $error("second_port_byte: expected %0h, actual %0h",
                       e.second_port_byte, second_b);
                errors++;
            end
            if (last_b !== e.last_bit)
            begin
                $error("last_bit: expected %0b, actual %0b", e.last_bit, last_b);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    // idle and stall odds in percent, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    xy2_bit_checker bit_chk = new();

    gxy2_cmd_if  cmd_ch ();
    gxy2_port_if port_ch ();

    galvo_xy2_frame_encoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .port  (port_ch)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: ready redrawn every cycle from the current stall odds
    always @(posedge clk)
    begin
        port_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // command monitor: every accepted command queues its twenty port items
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            bit_chk.note_command('{cmd_ch.action, cmd_ch.x_position,
                                   cmd_ch.y_position, cmd_ch.output_mode});
        end
    end

    // port monitor: each accepted port item is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && port_ch.valid && port_ch.ready)
        begin
            bit_chk.check_port_item(port_ch.first_port_byte, port_ch.second_port_byte,
                                    port_ch.last_bit);
        end
    end

    function automatic command_t mk_cmd(input logic a, input logic [15:0] x,
                                        input logic [15:0] y, input logic [7:0] m);
        command_t c;
        c.action      = a;
        c.x_position  = x;
        c.y_position  = y;
        c.output_mode = m;
        return c;
    endfunction

    // positions lean toward the rails now and then
    function automatic logic [15:0] pick_position();
        logic [15:0] p;
        case ($urandom_range(0, 7))
            0:       p = 16'h0000;
            1:       p = 16'hFFFF;
            default: p = 16'($urandom());
        endcase
        return p;
    endfunction

    // unused operands stay random so that the block must ignore them
    function automatic command_t random_command();
        return mk_cmd(1'($urandom()), pick_position(), pick_position(), 8'($urandom()));
    endfunction

    // hold valid low for a random gap, then present the item until it is taken
    task automatic send_command(input command_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= c.action;
        cmd_ch.x_position  <= c.x_position;
        cmd_ch.y_position  <= c.y_position;
        cmd_ch.output_mode <= c.output_mode;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // sender pauses until every queued port item has come back
    task automatic drain_port_items();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (bit_chk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_command(random_command());
        drain_port_items();
    endtask

    initial
    begin
        cmd_ch.valid       = 1'b0;
        cmd_ch.action      = ActPosition;
        cmd_ch.x_position  = '0;
        cmd_ch.y_position  = '0;
        cmd_ch.output_mode = '0;
        port_ch.ready      = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rst_n              = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rails, walking patterns, parity both ways, unused operands
        send_command(mk_cmd(ActPosition, 16'h0000, 16'h0000, 8'h00));
        send_command(mk_cmd(ActPosition, 16'hFFFF, 16'hFFFF, 8'h00));
        send_command(mk_cmd(ActPosition, 16'hFFFF, 16'h0000, 8'h00));
        send_command(mk_cmd(ActPosition, 16'h0000, 16'hFFFF, 8'h00));
        send_command(mk_cmd(ActPosition, 16'h5555, 16'hAAAA, 8'h00));
        send_command(mk_cmd(ActPosition, 16'hAAAA, 16'h5555, 8'h00));
        send_command(mk_cmd(ActPosition, 16'h8000, 16'h0001, 8'h00));
        send_command(mk_cmd(ActPosition, 16'h0001, 16'h8000, 8'h00));
        send_command(mk_cmd(ActPosition, 16'h0001, 16'h0003, 8'h00));
        send_command(mk_cmd(ActPosition, 16'h7FFF, 16'hFFFE, 8'h00));
        // position with a live mode byte, which has to be ignored
        send_command(mk_cmd(ActPosition, 16'h1234, 16'hFEDC, 8'hFF));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'h00));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'hFF));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'h01));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'h80));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'h55));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'hAA));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'h03));
        // mode with live positions, which have to be ignored
        send_command(mk_cmd(ActMode, 16'hFFFF, 16'hFFFF, 8'h5A));
        send_command(mk_cmd(ActMode, 16'hA5C3, 16'h3C5A, 8'hA5));
        // back to back position after mode and mode after position
        send_command(mk_cmd(ActPosition, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_command(mk_cmd(ActMode, 16'h0000, 16'h0000, 8'hFF));
        drain_port_items();

        // random phases: free flow, sender gaps, receiver stalls, both
        run_random_phase(0, 0, 102);
        run_random_phase(60, 0, 102);
        run_random_phase(0, 60, 102);
        run_random_phase(34, 34, 102);

        // tail window catches stray port items after the last frame
        repeat (50)
            @(posedge clk);
        if (bit_chk.errors == 0 && bit_chk.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #400_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gxy2_pkg.sv
hdl/gxy2_cmd_if.sv
hdl/gxy2_port_if.sv
hdl/gxy2_frame_build.sv
hdl/galvo_xy2_frame_encoder.sv
sim/tb_galvo_xy2_frame_encoder.sv
